/* rtl/serial_frame_decoder_assert.svh */
// Assertion macros for the serial frame decoder checker.
// Included by the checker file; needs no package of its own.
`ifndef SERIAL_FRAME_DECODER_ASSERT_SVH
`define SERIAL_FRAME_DECODER_ASSERT_SVH

// Check a property while out of reset.
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sfd_pkg.sv */
// Shared types and constants for the serial frame decoder.
// No dependencies; imported by the decoder and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // Frame start marker
  localparam logic [7:0] START_BYTE = 8'hFE;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_SUM_GOOD = 2'd1;
  localparam logic [1:0] KIND_SUM_BAD  = 2'd2;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
    logic        frame_last;
  } sfd_result_t;

endpackage

`default_nettype wire

/* rtl/sfd_if.sv */
// Valid/ready channel interfaces for the serial frame decoder.
// Input channel carries received bytes, result channel carries decoded words.
`timescale 1ns / 1ps
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] function_code;
  logic [15:0] payload_length;
  logic [15:0] byte_index;
  logic [7:0]  payload_byte;
  logic        frame_last;

  modport source (
    output valid, output kind, output function_code, output payload_length,
    output byte_index, output payload_byte, output frame_last, input ready
  );
  modport sink (
    input valid, input kind, input function_code, input payload_length,
    input byte_index, input payload_byte, input frame_last, output ready
  );
endinterface

`default_nettype wire

/* rtl/serial_frame_decoder.sv */
// Serial frame decoder top level: frame parser, output register and skid stage.
// Depends on sfd_pkg and the channel interfaces in sfd_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per clock and parses frames of the form 0xFE,
// function code (MSB first), payload length (MSB first), payload, checksum.
// Each payload byte leaves as one word with its index; the checksum byte
// yields one frame-end word whose kind tells whether the XOR of all bytes from
// the start byte through the last payload byte matched. Bytes outside a frame
// are dropped silently. A byte is taken every cycle while the skid stage is
// empty; its result is registered in the output register, or in the skid stage
// if the output stalls. The rate is set by the parse phase and running XOR.
// A stalled result sits in the output register while one more word fills the
// skid stage, after which input is held off until the result side drains.
module serial_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  sfd_in_if.sink      in_ch,
  sfd_out_if.source   out_ch
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_FMSB,
    PH_FLSB,
    PH_LMSB,
    PH_LLSB,
    PH_DATA,
    PH_CSUM
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] function_r, function_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  xor_r, xor_nxt;

  sfd_result_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfd_result_t skid_r, skid_nxt;
  logic        skid_valid_r, skid_valid_nxt;

  sfd_result_t res;
  logic        res_valid;
  logic        in_fire;
  logic [7:0]  rx;
  logic [15:0] count_inc;
  logic [15:0] length_new;

  // Accept whenever the skid stage has room
  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && !skid_valid_r;
  assign rx          = in_ch.rx_byte;
  assign count_inc   = count_r + 16'd1;
  assign length_new  = {length_r[15:8], rx};

  // Parse one byte: advance phase, fold into XOR, build result word
  always_comb begin
    phase_nxt    = phase_r;
    function_nxt = function_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    res_valid    = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.function_code  = function_r;
    res.payload_length = length_r;
    res.byte_index     = count_r;
    res.payload_byte   = rx;
    res.frame_last     = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx == START_BYTE) begin
            xor_nxt   = START_BYTE;
            count_nxt = 16'd0;
            phase_nxt = PH_FMSB;
          end
        end
        PH_FMSB: begin
          function_nxt = {rx, 8'd0};
          xor_nxt      = xor_r ^ rx;
          phase_nxt    = PH_FLSB;
        end
        PH_FLSB: begin
          function_nxt = {function_r[15:8], rx};
          xor_nxt      = xor_r ^ rx;
          phase_nxt    = PH_LMSB;
        end
        PH_LMSB: begin
          length_nxt = {rx, 8'd0};
          xor_nxt    = xor_r ^ rx;
          phase_nxt  = PH_LLSB;
        end
        PH_LLSB: begin
          length_nxt = length_new;
          xor_nxt    = xor_r ^ rx;
          count_nxt  = 16'd0;
          phase_nxt  = (length_new == 16'd0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          res_valid = 1'b1;
          xor_nxt   = xor_r ^ rx;
          count_nxt = count_inc;
          if (count_inc >= length_r) begin
            count_nxt = 16'd0;
            phase_nxt = PH_CSUM;
          end
        end
        PH_CSUM: begin
          res_valid        = 1'b1;
          res.kind         = (xor_r == rx) ? KIND_SUM_GOOD : KIND_SUM_BAD;
          res.byte_index   = 16'd0;
          res.payload_byte = 8'd0;
          res.frame_last   = 1'b1;
          phase_nxt        = PH_WAIT;
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  // Steer results through the output register and skid stage
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && !out_ch.ready) begin
      if (res_valid) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_nxt       = res;
      skid_valid_nxt = res_valid;
    end else begin
      out_nxt       = res;
      out_valid_nxt = res_valid;
    end
  end

  // Hold parse state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      function_r   <= 16'd0;
      length_r     <= 16'd0;
      count_r      <= 16'd0;
      xor_r        <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      function_r   <= function_nxt;
      length_r     <= length_nxt;
      count_r      <= count_nxt;
      xor_r        <= xor_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // Drive the result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.function_code  = out_r.function_code;
  assign out_ch.payload_length = out_r.payload_length;
  assign out_ch.byte_index     = out_r.byte_index;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.frame_last     = out_r.frame_last;

endmodule

`default_nettype wire

/* rtl/sfd_checker.sv */
// Port-level checker for the serial frame decoder, bound to the top level.
// Depends on sfd_pkg and serial_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_decoder_assert.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_payload_length,
  input logic [15:0] out_byte_index,
  input logic [7:0]  out_payload_byte,
  input logic        out_frame_last
);
  import sfd_pkg::*;

  // Frame-end flag and kind agree
  `SFD_ASSERT(a_last_kind, clk, rst_n, out_valid |-> (out_frame_last == (out_kind != KIND_PAYLOAD)), "frame_last disagrees with kind")

  // Frame-end word carries zero index and byte
  `SFD_ASSERT(a_end_zero, clk, rst_n, (out_valid && out_frame_last) |-> (out_byte_index == 16'd0 && out_payload_byte == 8'd0), "frame end word not zeroed")

  // Payload index stays inside the declared length
  `SFD_ASSERT(a_index_range, clk, rst_n, (out_valid && !out_frame_last) |-> (out_byte_index < out_payload_length), "payload index beyond length")

  // Stalled word stays offered
  `SFD_ASSERT(a_hold_valid, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

  // Reset empties the result side
  `SFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind serial_frame_decoder sfd_checker u_sfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_payload_length (out_ch.payload_length),
  .out_byte_index     (out_ch.byte_index),
  .out_payload_byte   (out_ch.payload_byte),
  .out_frame_last     (out_ch.frame_last)
);

`default_nettype wire
